[hdl/ssm_pkg.sv]
package ssm_pkg;

    localparam int SEGMENT_BYTES        = 32768;
    localparam int SERVERS_PER_GROUP    = 5;
    localparam int CHECKSUM_GROUP_BYTES = 131072;
    localparam int MAX_GROUPS           = 16;
    localparam int MAX_REQUEST_BYTES    = 1048576;
    localparam int MAX_RESULTS          = 33;

    localparam int OFF_W   = 48;
    localparam int SIZE_W  = 21;
    localparam int BYTES_W = 16;
    localparam int SLOT_W  = 4;
    localparam int GSEG_W  = 34;
    localparam int GC_W    = 5;
    localparam int CNT_W   = 6;
    localparam int SEG_LOG = $clog2(SEGMENT_BYTES);
    localparam int CG_LOG  = $clog2(CHECKSUM_GROUP_BYTES);
    localparam int CGS_W   = OFF_W - CG_LOG;

    localparam logic CMD_MAP = 1'b0;
    localparam logic CMD_END = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [OFF_W-1:0]   file_offset_in;
        logic [SIZE_W-1:0]  request_bytes;
    } t_in_item;

    typedef struct packed {
        logic [OFF_W-1:0]   seg_file_offset;
        logic [BYTES_W-1:0] seg_bytes;
        logic [SLOT_W-1:0]  group_slot;
        logic [OFF_W-1:0]   group_byte_offset;
        logic [GSEG_W-1:0]  group_segment;
        logic               last;
    } t_out_item;

    // classified item held in the queue
    typedef struct packed {
        logic               cmd;
        logic [OFF_W-1:0]   off;
        logic [SIZE_W-1:0]  size;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_back_state;

endpackage

[hdl/ssm_front.sv]
module ssm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ssm_pkg::t_in_item i_in_data,
    input  logic              i_pop,
    output logic              o_job_valid,
    output ssm_pkg::t_job     o_job
);
    import ssm_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_job       w_job;

    // zero-length map requests give no result and are dropped here
    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push = i_in_valid && !o_in_stall
                    && !(i_in_data.cmd == CMD_MAP && i_in_data.request_bytes == '0);
    assign w_pop = i_pop && (r_cnt != 2'd0);

    always_comb begin
        w_job.cmd = i_in_data.cmd;
        w_job.off = i_in_data.file_offset_in;
        if (i_in_data.request_bytes > SIZE_W'(MAX_REQUEST_BYTES)) begin
            w_job.size = SIZE_W'(MAX_REQUEST_BYTES);
        end else begin
            w_job.size = i_in_data.request_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_mem[r_rp];

endmodule

[hdl/ssm_div.sv]
module ssm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ssm_pkg::CGS_W-1:0]   i_dividend,
    input  logic [ssm_pkg::GC_W-1:0]    i_divisor,
    output logic                        o_done,
    output logic [ssm_pkg::CGS_W-1:0]   o_quot,
    output logic [ssm_pkg::SLOT_W-1:0]  o_rem
);
    import ssm_pkg::*;

    localparam int STEP_W = $clog2(CGS_W);

    logic [CGS_W-1:0]  r_q;
    logic [SLOT_W-1:0] r_rem;
    logic [GC_W-1:0]   r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [GC_W-1:0]   w_trial;
    logic              w_ge;

    // restoring division, one quotient bit a cycle
    assign w_trial = {r_rem, r_q[CGS_W-1]};
    assign w_ge    = (w_trial >= r_div);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[CGS_W-2:0], w_ge};
            r_rem <= w_ge ? SLOT_W'(w_trial - r_div) : SLOT_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CGS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

[hdl/ssm_back.sv]
module ssm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ssm_pkg::GC_W-1:0]  i_groups,
    input  logic                      i_job_valid,
    input  ssm_pkg::t_job             i_job,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output ssm_pkg::t_out_item        o_out_data
);
    import ssm_pkg::*;

    t_back_state       r_state;
    t_back_state       n_state;
    logic              w_div_start;
    logic              w_div_done;
    logic [CGS_W-1:0]  w_quot;
    logic [SLOT_W-1:0] w_rem;

    logic              r_cmd;
    logic              r_first;
    logic [OFF_W-1:0]  r_off;
    logic [SIZE_W-1:0] r_size;
    logic [SLOT_W-1:0] r_slot;
    logic [OFF_W-1:0]  r_goff;
    logic [OFF_W-1:0]  r_start;
    logic [GSEG_W-1:0] r_gseg;
    logic [CNT_W-1:0]  r_k;
    logic [SLOT_W-1:0] r_i;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              r_kick;

    logic              w_out_free;
    logic              w_fire;
    t_out_item         w_item;

    logic [SEG_LOG-1:0] w_seg_off;
    logic [BYTES_W-1:0] w_room;
    logic [BYTES_W-1:0] w_piece_first;
    logic [SIZE_W-1:0]  w_size_al;
    logic [SIZE_W-1:0]  w_nsize;
    logic [BYTES_W-1:0] w_piece;
    logic [OFF_W-1:0]   w_goff_inc;
    logic [GC_W-1:0]    w_slot_inc;
    logic               w_wrap_n;
    logic [OFF_W-1:0]   w_nstart;
    logic [SLOT_W-1:0]  w_nslot;
    logic [OFF_W-1:0]   w_ngoff;
    logic [CNT_W-1:0]   w_nk;
    logic [OFF_W-1:0]   w_div_goff;

    ssm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_off[OFF_W-1:CG_LOG]),
        .i_divisor  (i_groups),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_job_valid) n_state = ST_DIV;
            ST_DIV:  if (w_div_done) n_state = ST_EMIT;
            ST_EMIT: if (w_out_free && w_item.last) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop       = 1'b0;
        w_fire      = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop = i_job_valid;
            ST_DIV:  w_div_start = r_kick;
            ST_EMIT: w_fire = w_out_free;
            default: o_pop = 1'b0;
        endcase
    end

    // divider starts the cycle after the job is latched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick <= 1'b0;
        end else begin
            r_kick <= o_pop;
        end
    end

    assign w_div_goff = {w_quot, r_off[CG_LOG-1:0]};

    // map arithmetic
    always_comb begin
        w_seg_off     = r_off[SEG_LOG-1:0];
        w_room        = BYTES_W'(SEGMENT_BYTES) - BYTES_W'(w_seg_off);
        w_piece_first = (r_size < SIZE_W'(w_room)) ? BYTES_W'(r_size) : w_room;
        w_size_al     = r_size + SIZE_W'(w_seg_off);
        w_nsize       = r_size - SIZE_W'(SEGMENT_BYTES);
        w_piece       = (w_nsize < SIZE_W'(SEGMENT_BYTES)) ? BYTES_W'(w_nsize)
                                                            : BYTES_W'(SEGMENT_BYTES);
        w_goff_inc    = r_goff + OFF_W'(SEGMENT_BYTES);
        w_slot_inc    = {1'b0, r_slot} + 1'b1;
        w_wrap_n      = (w_slot_inc >= i_groups);
        w_nstart      = w_wrap_n ? r_start + OFF_W'(CHECKSUM_GROUP_BYTES) : r_start;
        w_nslot       = w_wrap_n ? '0 : SLOT_W'(w_slot_inc);
        w_nk          = r_k + 1'b1;
        if (w_goff_inc[CG_LOG-1:0] == '0) begin
            w_ngoff = w_nstart;
        end else begin
            w_ngoff = w_goff_inc;
        end
    end

    // result item for the current step
    always_comb begin
        w_item = '0;
        w_item.seg_file_offset = r_off;
        if (r_cmd == CMD_END) begin
            w_item.seg_bytes  = '0;
            w_item.group_slot = r_i;
            if (r_i < r_slot) begin
                w_item.group_byte_offset = r_start + OFF_W'(CHECKSUM_GROUP_BYTES);
                w_item.group_segment = GSEG_W'(r_start[OFF_W-1:SEG_LOG])
                                       + GSEG_W'(SERVERS_PER_GROUP);
            end else if (r_i == r_slot) begin
                w_item.group_byte_offset = r_goff;
                w_item.group_segment     = r_gseg;
            end else begin
                w_item.group_byte_offset = r_start;
                w_item.group_segment     = GSEG_W'(r_start[OFF_W-1:SEG_LOG]);
            end
            w_item.last = ({1'b0, r_i} == i_groups - 1'b1);
        end else if (r_first) begin
            w_item.seg_bytes         = w_piece_first;
            w_item.group_slot        = r_slot;
            w_item.group_byte_offset = r_goff;
            w_item.group_segment     = r_gseg;
            w_item.last              = (w_size_al <= SIZE_W'(SEGMENT_BYTES));
        end else begin
            w_item.seg_file_offset   = r_off + OFF_W'(SEGMENT_BYTES);
            w_item.seg_bytes         = w_piece;
            w_item.group_slot        = (w_goff_inc[CG_LOG-1:0] == '0) ? w_nslot : r_slot;
            w_item.group_byte_offset = w_ngoff;
            w_item.group_segment     = r_gseg + 1'b1;
            w_item.last = (w_nsize <= SIZE_W'(SEGMENT_BYTES))
                          || (w_nk == CNT_W'(MAX_RESULTS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_job.cmd;
            r_off  <= i_job.off;
            r_size <= i_job.size;
        end else if (r_state == ST_DIV && w_div_done) begin
            r_slot  <= w_rem;
            r_goff  <= w_div_goff;
            r_start <= {w_quot, {CG_LOG{1'b0}}};
            r_gseg  <= GSEG_W'(w_div_goff[OFF_W-1:SEG_LOG]);
            r_first <= 1'b1;
            r_i     <= '0;
            r_k     <= CNT_W'(1);
        end else if (w_fire) begin
            if (r_cmd == CMD_END) begin
                r_i <= r_i + 1'b1;
            end else if (r_first) begin
                // align the walk to the segment start
                r_first <= 1'b0;
                r_off   <= {r_off[OFF_W-1:SEG_LOG], {SEG_LOG{1'b0}}};
                r_size  <= w_size_al;
                r_goff  <= {r_goff[OFF_W-1:SEG_LOG], {SEG_LOG{1'b0}}};
            end else begin
                r_off  <= r_off + OFF_W'(SEGMENT_BYTES);
                r_size <= w_nsize;
                r_goff <= w_ngoff;
                r_gseg <= r_gseg + 1'b1;
                r_k    <= w_nk;
                if (w_goff_inc[CG_LOG-1:0] == '0) begin
                    r_slot  <= w_nslot;
                    r_start <= w_nstart;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hdl/stripe_segment_mapper_top.sv]
// stripe segment mapper: a map transaction (offset, length) yields one result per
// segment touched, with the group slot, the offset and segment number inside the
// group's local space, last set on the final one; zero length gives nothing. an
// end transaction yields one end position per group slot. each transaction first
// runs a bit-serial division of its checksum-group index by the group count, then
// emits one result per cycle while the output is not stalled (at most 33 results
// for a map, group_count for an end). a two-entry queue sits between the input
// side and the sequencer, so input transactions are taken while results drain.
module stripe_segment_mapper_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ssm_pkg::t_in_item  i_in_data,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ssm_pkg::t_out_item o_out_data,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ssm_pkg::*;

    logic [GC_W-1:0] r_group_count;
    logic [GC_W-1:0] w_groups;
    logic            w_job_valid;
    t_job            w_job;
    logic            w_pop;

    // register write on the access phase, group_count at address 0 (any address with paddr[2] low)
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= GC_W'(1);
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_group_count <= pwdata[GC_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {{(32-GC_W){1'b0}}, r_group_count};

    // zero acts as one group, values above the maximum saturate
    always_comb begin
        if (r_group_count == '0) begin
            w_groups = GC_W'(1);
        end else if (r_group_count > GC_W'(MAX_GROUPS)) begin
            w_groups = GC_W'(MAX_GROUPS);
        end else begin
            w_groups = r_group_count;
        end
    end

    // input side: accept, drop empty ranges, saturate length, queue
    ssm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_pop       (w_pop),
        .o_job_valid (w_job_valid),
        .o_job       (w_job)
    );

    // sequencer: divide, then walk segments or group slots
    ssm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_groups    (w_groups),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
